// ===== sv/skt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skt_pkg
// shared widths, request and status codes and the entry layout of the
// sorted key table
// ----------------------------------------------------------------------------
package skt_pkg;

	localparam int DEPTH_DEF  = 16;

	localparam int KEY_W      = 32;
	localparam int PAY_W      = 32;
	localparam int REQ_W      = 2;
	localparam int STAT_W     = 3;
	localparam int CNT_OUT_W  = 5;

	localparam int IN_TDATA_W  = KEY_W + PAY_W;
	localparam int OUT_TDATA_W = STAT_W + PAY_W + CNT_OUT_W;

	// request kinds
	localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
	localparam logic [REQ_W-1:0] REQ_DELETE = 2'd1;
	localparam logic [REQ_W-1:0] REQ_SEARCH = 2'd2;

	// result status codes
	localparam logic [STAT_W-1:0] STAT_OK       = 3'd0;
	localparam logic [STAT_W-1:0] STAT_FULL     = 3'd1;
	localparam logic [STAT_W-1:0] STAT_RANGE    = 3'd2;
	localparam logic [STAT_W-1:0] STAT_DUP      = 3'd3;
	localparam logic [STAT_W-1:0] STAT_NOTFOUND = 3'd4;

	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic [PAY_W-1:0] payload;
	} entry_t;

endpackage

// ===== sv/sorted_key_table.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_key_table
// table of up to DEPTH key/payload entries kept in ascending key order,
// with insert, delete and search by key
// ----------------------------------------------------------------------------
// The entries live in one single-port-read, single-port-write memory with a
// registered read. A request is taken only while the block is idle and gives
// exactly one result item. A search or a rejected request costs a linear scan
// of the stored entries, one read per cycle, ending early when the key is
// passed; an insert or delete stops the scan at its slot and then moves only
// the entries above that slot, one entry per cycle through the same memory
// port. Requests rejected up front (table full, key out of range, empty
// table, unused request code) go from idle straight to the result state.
// The result sits in an output register, so the next item is taken while it
// waits. max_key is written through the cfg channel, which is always ready;
// it must only change while no request is in flight. The memory needs no
// clearing after reset: only slots below the fill count are ever read.
// ----------------------------------------------------------------------------
module sorted_key_table
	import skt_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,

	// request stream
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [IN_TDATA_W-1:0]  s_tdata,  // key[31:0], payload[63:32]
	input  logic [REQ_W-1:0]       s_tuser,  // req_type[1:0]

	// result stream
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata,  // status[2:0], found_payload[34:3],
	                                         // entry_count[39:35]

	// max_key register write
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [KEY_W-1:0]       cfg_data
);

	localparam int ADDR_W = $clog2(DEPTH);
	localparam int CNT_W  = $clog2(DEPTH + 1);

	// sequencer states
	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_SCAN = 3'd1; // linear search over valid slots
	localparam logic [2:0] S_SHUP = 3'd2; // move entries up, then place new one
	localparam logic [2:0] S_SHDN = 3'd3; // move entries down over deleted slot
	localparam logic [2:0] S_FIN  = 3'd4; // hand result to output register

	logic [2:0]        state_q;
	logic [REQ_W-1:0]  req_q;
	logic [KEY_W-1:0]  key_q;
	logic [PAY_W-1:0]  pay_q;
	logic [CNT_W-1:0]  fill_q;
	logic [KEY_W-1:0]  max_key_q;

	// scan pointer and the slot whose read data is on rd_data_s1
	logic [CNT_W-1:0]  rd_ptr_q;
	logic              chk_vld_s1;
	logic [CNT_W-1:0]  chk_idx_s1;

	// shift pass
	logic [ADDR_W-1:0] pos_q;
	logic [ADDR_W-1:0] sh_addr_q;
	logic [CNT_W-1:0]  sh_left_q;
	logic              wr_pend_s1;
	logic [ADDR_W-1:0] wr_addr_s1;

	// result being built and the output register
	logic [STAT_W-1:0] res_status_q;
	logic [PAY_W-1:0]  res_pay_q;
	logic              out_vld_q;
	logic [STAT_W-1:0] out_status_q;
	logic [PAY_W-1:0]  out_pay_q;
	logic [CNT_OUT_W-1:0] out_cnt_q;

	// memory ports
	entry_t            entry_mem [DEPTH];
	entry_t            rd_data_s1;
	logic              rd_en;
	logic [ADDR_W-1:0] rd_addr;
	logic              wr_en;
	logic [ADDR_W-1:0] wr_addr;
	entry_t            wr_data;

	logic [KEY_W-1:0]  in_key;
	logic [PAY_W-1:0]  in_pay;
	logic              in_range;
	logic              accept;
	logic              out_free;
	logic              scan_rd;
	logic              shift_done;
	logic              chk_hit;
	logic              chk_above;
	logic              chk_last;

	assign in_key   = s_tdata[KEY_W-1:0];
	assign in_pay   = s_tdata[IN_TDATA_W-1:KEY_W];
	assign in_range = (in_key != '0) && (in_key <= max_key_q);

	assign s_tready  = (state_q == S_IDLE);
	assign accept    = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;
	assign out_free  = !out_vld_q || m_tready;

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {out_cnt_q, out_pay_q, out_status_q};

	// the compare sees each scan read in the cycle after it is issued
	assign scan_rd    = (state_q == S_SCAN) && (rd_ptr_q < fill_q);
	assign shift_done = (sh_left_q == '0) && !wr_pend_s1;

	assign chk_hit   = (rd_data_s1.key == key_q);
	assign chk_above = (rd_data_s1.key > key_q);
	assign chk_last  = (chk_idx_s1 == fill_q - CNT_W'(1));

	// memory port control
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = sh_addr_q;
		wr_en   = 1'b0;
		wr_addr = wr_addr_s1;
		wr_data = rd_data_s1;
		if (state_q == S_SCAN) begin
			rd_en   = scan_rd;
			rd_addr = rd_ptr_q[ADDR_W-1:0];
		end else if (state_q == S_SHUP || state_q == S_SHDN) begin
			rd_en = (sh_left_q != '0);
			if (wr_pend_s1) begin
				// moved entry lands one slot over
				wr_en = 1'b1;
			end else if (sh_left_q == '0) begin
				wr_en = 1'b1;
				if (state_q == S_SHUP) begin
					// new entry into the opened slot
					wr_addr = pos_q;
					wr_data = '{key: key_q, payload: pay_q};
				end else begin
					// clear the vacated last slot
					wr_addr = ADDR_W'(fill_q - CNT_W'(1));
					wr_data = '0;
				end
			end
		end
	end

	// table memory, registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			entry_mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_s1 <= entry_mem[rd_addr];
		end
	end

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_key_q <= '1;
		end else if (cfg_valid && cfg_ready) begin
			max_key_q <= cfg_data;
		end
	end

	// shift write pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_pend_s1 <= 1'b0;
		end else if (state_q == S_SHUP || state_q == S_SHDN) begin
			wr_pend_s1 <= (sh_left_q != '0);
		end else begin
			wr_pend_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_SHUP) begin
			wr_addr_s1 <= sh_addr_q + ADDR_W'(1);
		end else begin
			wr_addr_s1 <= sh_addr_q - ADDR_W'(1);
		end
		chk_idx_s1 <= rd_ptr_q;
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			fill_q       <= '0;
			chk_vld_s1   <= 1'b0;
			rd_ptr_q     <= '0;
			sh_left_q    <= '0;
			req_q        <= REQ_INSERT;
			res_status_q <= STAT_OK;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						req_q      <= s_tuser;
						key_q      <= in_key;
						pay_q      <= in_pay;
						res_pay_q  <= '0;
						rd_ptr_q   <= '0;
						chk_vld_s1 <= 1'b0;
						sh_left_q  <= '0;
						pos_q      <= '0;
						state_q    <= S_FIN;
						case (s_tuser)
							REQ_INSERT: begin
								if (fill_q == CNT_W'(DEPTH)) begin
									res_status_q <= STAT_FULL;
								end else if (!in_range) begin
									res_status_q <= STAT_RANGE;
								end else if (fill_q == '0) begin
									// empty table: place straight into slot zero
									state_q <= S_SHUP;
								end else begin
									state_q <= S_SCAN;
								end
							end
							REQ_DELETE: begin
								if (!in_range) begin
									res_status_q <= STAT_RANGE;
								end else if (fill_q == '0) begin
									res_status_q <= STAT_NOTFOUND;
								end else begin
									state_q <= S_SCAN;
								end
							end
							REQ_SEARCH: begin
								if (fill_q == '0) begin
									res_status_q <= STAT_NOTFOUND;
								end else begin
									state_q <= S_SCAN;
								end
							end
							default: begin
								res_status_q <= STAT_NOTFOUND;
							end
						endcase
					end
				end

				S_SCAN: begin
					if (scan_rd) begin
						rd_ptr_q <= rd_ptr_q + CNT_W'(1);
					end
					chk_vld_s1 <= scan_rd;
					if (chk_vld_s1) begin
						case (req_q)
							REQ_INSERT: begin
								if (chk_hit) begin
									res_status_q <= STAT_DUP;
									state_q      <= S_FIN;
								end else if (chk_above) begin
									// first larger key: open its slot
									pos_q     <= chk_idx_s1[ADDR_W-1:0];
									sh_addr_q <= ADDR_W'(fill_q - CNT_W'(1));
									sh_left_q <= fill_q - chk_idx_s1;
									state_q   <= S_SHUP;
								end else if (chk_last) begin
									// largest key so far: append
									pos_q     <= fill_q[ADDR_W-1:0];
									sh_left_q <= '0;
									state_q   <= S_SHUP;
								end
							end
							REQ_DELETE: begin
								if (chk_hit) begin
									sh_addr_q <= ADDR_W'(chk_idx_s1 + CNT_W'(1));
									sh_left_q <= fill_q - CNT_W'(1) - chk_idx_s1;
									state_q   <= S_SHDN;
								end else if (chk_above || chk_last) begin
									res_status_q <= STAT_NOTFOUND;
									state_q      <= S_FIN;
								end
							end
							default: begin
								if (chk_hit) begin
									res_status_q <= STAT_OK;
									res_pay_q    <= rd_data_s1.payload;
									state_q      <= S_FIN;
								end else if (chk_above || chk_last) begin
									res_status_q <= STAT_NOTFOUND;
									state_q      <= S_FIN;
								end
							end
						endcase
					end
				end

				S_SHUP: begin
					if (sh_left_q != '0) begin
						sh_addr_q <= sh_addr_q - ADDR_W'(1);
						sh_left_q <= sh_left_q - CNT_W'(1);
					end else if (shift_done) begin
						fill_q       <= fill_q + CNT_W'(1);
						res_status_q <= STAT_OK;
						state_q      <= S_FIN;
					end
				end

				S_SHDN: begin
					if (sh_left_q != '0) begin
						sh_addr_q <= sh_addr_q + ADDR_W'(1);
						sh_left_q <= sh_left_q - CNT_W'(1);
					end else if (shift_done) begin
						fill_q       <= fill_q - CNT_W'(1);
						res_status_q <= STAT_OK;
						state_q      <= S_FIN;
					end
				end

				S_FIN: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end

				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (state_q == S_FIN && out_free) begin
			out_vld_q <= 1'b1;
		end else if (m_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_FIN && out_free) begin
			out_status_q <= res_status_q;
			out_pay_q    <= res_pay_q;
			out_cnt_q    <= CNT_OUT_W'(fill_q);
		end
	end

	// the fill count never passes the capacity
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CNT_W'(DEPTH))
		else $error("fill count above capacity");

	// a change of the count is always a step of exactly one
	a_fill_step: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(fill_q) |->
			(fill_q == $past(fill_q) + CNT_W'(1)) ||
			(fill_q == $past(fill_q) - CNT_W'(1)))
		else $error("fill count jumped");

	// the table is only written during a shift pass
	a_wr_shift: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (state_q == S_SHUP || state_q == S_SHDN))
		else $error("memory write outside shift pass");

	// a count change always completes a request that then reports ok
	a_fill_ok: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(fill_q) |-> (state_q == S_FIN && res_status_q == STAT_OK))
		else $error("fill count changed without ok result");

endmodule
